// ----- design/mslp_pkg.sv -----
// Shared types, constants and codes for the multi-state LRU pool.
package mslp_pkg;

  localparam int ELEMENTS = 1024;
  localparam int STATES   = 8;
  localparam int IDX_W    = $clog2(ELEMENTS);
  localparam int LINK_W   = IDX_W + 1;
  localparam int STATE_W  = 3;
  localparam int STAMP_W  = 48;
  localparam int CNT_W    = 11;
  localparam int CMD_W    = 3;
  localparam int STS_W    = 2;
  localparam int SIU_W    = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 4;
  localparam int INFO_W   = STATE_W + STAMP_W;

  localparam logic [LINK_W-1:0]  NIL       = LINK_W'(ELEMENTS);
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MOVE_IDX = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE_OLD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_Q_STATE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_Q_ELEM   = 3'd4;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_WRONG = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STS_W-1:0] STS_BAD   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STATES_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMED_MODE    = 4'd1;

  // One queue descriptor: head, tail and length of a state
  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
    logic [CNT_W-1:0]  len;
  } qent_t;

  // Result of one transaction
  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [IDX_W-1:0]   result_index;
    logic [STATE_W-1:0] current_state;
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   state_count;
  } result_t;

endpackage

// ----- design/mslp_in_if.sv -----
// Command channel interface.
interface mslp_in_if;
  logic                              valid;
  logic                              ready;
  logic [mslp_pkg::CMD_W-1:0]        cmd;
  logic [mslp_pkg::IDX_W-1:0]        element_index;
  logic [mslp_pkg::STATE_W-1:0]      src_state;
  logic [mslp_pkg::STATE_W-1:0]      dst_state;
  logic [mslp_pkg::STAMP_W-1:0]      now;
  modport source (output valid, cmd, element_index, src_state, dst_state, now, input ready);
  modport sink (input valid, cmd, element_index, src_state, dst_state, now, output ready);
endinterface

// ----- design/mslp_out_if.sv -----
// Result channel interface.
interface mslp_out_if;
  logic                          valid;
  logic                          ready;
  logic [mslp_pkg::STS_W-1:0]    status;
  logic [mslp_pkg::IDX_W-1:0]    result_index;
  logic [mslp_pkg::STATE_W-1:0]  current_state;
  logic [mslp_pkg::STAMP_W-1:0]  stamp;
  logic [mslp_pkg::CNT_W-1:0]    state_count;
  modport source (output valid, status, result_index, current_state, stamp, state_count,
                  input ready);
  modport sink (input valid, status, result_index, current_state, stamp, state_count,
                output ready);
endinterface

// ----- design/mslp_cfg_if.sv -----
// Configuration write channel interface.
interface mslp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mslp_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [mslp_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// ----- design/mslp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mslp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/mslp_qtab.sv -----
// Per-state queue descriptor table, one selected entry read and written a cycle.
module mslp_qtab (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mslp_pkg::STATE_W-1:0]  sel,
  input  logic                          we,
  input  mslp_pkg::qent_t               wdata,
  output mslp_pkg::qent_t               rdata
);

  mslp_pkg::qent_t tab_r [mslp_pkg::STATES];

  assign rdata = tab_r[sel];

  // Reset puts every element in state 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mslp_pkg::STATES; i++) begin
        if (i == 0) begin
          tab_r[i].head <= mslp_pkg::LINK_W'(mslp_pkg::ELEMENTS - 1);
          tab_r[i].tail <= '0;
          tab_r[i].len  <= mslp_pkg::CNT_W'(mslp_pkg::ELEMENTS);
        end else begin
          tab_r[i].head <= mslp_pkg::NIL;
          tab_r[i].tail <= mslp_pkg::NIL;
          tab_r[i].len  <= '0;
        end
      end
    end else if (we) begin
      tab_r[sel] <= wdata;
    end
  end

endmodule

// ----- design/multi_state_lru_pool.sv -----
// Top level: sequencer over link memories and the queue table of the LRU pool.
// Bad argument or empty queue go straight to the result; queries and wrong-state
// moves read the memories first; moves and touches step through read, unlink,
// link, tail fix, result and output register. One transaction at a time: the next
// command is taken after the result register loads, and a stall on the result
// side holds the sequencer in its output state. After reset a clearing pass
// initializes the link, state and stamp memories; the command channel waits.
module multi_state_lru_pool (
  input  logic       clk,
  input  logic       rst_n,
  mslp_in_if.sink    in_ch,
  mslp_out_if.source out_ch,
  mslp_cfg_if.sink   cfg_ch
);

  typedef enum logic [6:0] {
    S_CLR    = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EVAL   = 7'b0000100,
    S_UNLINK = 7'b0001000,
    S_LINK   = 7'b0010000,
    S_FIX    = 7'b0100000,
    S_OUT    = 7'b1000000
  } fsm_t;

  fsm_t fsm_r, fsm_nxt;

  logic [mslp_pkg::SIU_W-1:0]   siu_r;
  logic                         timed_r;
  logic [mslp_pkg::IDX_W-1:0]   clr_r;
  logic [mslp_pkg::CMD_W-1:0]   cmd_r;
  logic [mslp_pkg::STATE_W-1:0] os_r, ns_r, src_r, dst_r;
  logic [mslp_pkg::STAMP_W-1:0] now_r, ctr_r, stamp_new_r;
  logic [mslp_pkg::IDX_W-1:0]   e_r;
  logic [mslp_pkg::LINK_W-1:0]  n_r, p_r, t_r;
  mslp_pkg::result_t            res_r, res_nxt;
  mslp_pkg::result_t            out_r;
  logic                         out_valid_r;

  // Memory ports
  logic                         nx_we, pv_we, inf_we, rd_en;
  logic [mslp_pkg::IDX_W-1:0]   nx_wa, pv_wa, inf_wa, rd_a;
  logic [mslp_pkg::LINK_W-1:0]  nx_wd, pv_wd, nx_q, pv_q;
  logic [mslp_pkg::INFO_W-1:0]  inf_wd, inf_q;

  // Queue table port
  logic [mslp_pkg::STATE_W-1:0] q_sel;
  logic                         q_we;
  mslp_pkg::qent_t              q_wd, q_rd;

  logic in_acc, os_ok, ns_ok, idx_ok, bad, empty;
  logic [mslp_pkg::STATE_W-1:0] st_q;
  logic [mslp_pkg::STAMP_W-1:0] stp_q, stamp_calc;

  mslp_ram #(.WIDTH(mslp_pkg::LINK_W), .DEPTH(mslp_pkg::ELEMENTS)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .re(rd_en), .raddr(rd_a), .rdata(nx_q));
  mslp_ram #(.WIDTH(mslp_pkg::LINK_W), .DEPTH(mslp_pkg::ELEMENTS)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .re(rd_en), .raddr(rd_a), .rdata(pv_q));
  mslp_ram #(.WIDTH(mslp_pkg::INFO_W), .DEPTH(mslp_pkg::ELEMENTS)) u_info (
    .clk, .we(inf_we), .waddr(inf_wa), .wdata(inf_wd), .re(rd_en), .raddr(rd_a),
    .rdata(inf_q));

  mslp_qtab u_qtab (.clk, .rst_n, .sel(q_sel), .we(q_we), .wdata(q_wd), .rdata(q_rd));

  assign in_ch.ready  = (fsm_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign st_q         = inf_q[mslp_pkg::INFO_W-1 -: mslp_pkg::STATE_W];
  assign stp_q        = inf_q[mslp_pkg::STAMP_W-1:0];

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.result_index  = out_r.result_index;
  assign out_ch.current_state = out_r.current_state;
  assign out_ch.stamp         = out_r.stamp;
  assign out_ch.state_count   = out_r.state_count;

  // Argument checks at acceptance
  always_comb begin
    os_ok  = ({1'b0, in_ch.src_state} < siu_r) &&
             ({1'b0, in_ch.src_state} < mslp_pkg::SIU_W'(mslp_pkg::STATES));
    ns_ok  = ({1'b0, in_ch.dst_state} < siu_r) &&
             ({1'b0, in_ch.dst_state} < mslp_pkg::SIU_W'(mslp_pkg::STATES));
    idx_ok = {1'b0, in_ch.element_index} < mslp_pkg::LINK_W'(mslp_pkg::ELEMENTS);
    unique case (in_ch.cmd) inside
      mslp_pkg::CMD_MOVE_IDX: bad = !idx_ok || !os_ok || !ns_ok;
      mslp_pkg::CMD_MOVE_OLD: bad = !os_ok || !ns_ok;
      mslp_pkg::CMD_Q_STATE:  bad = !os_ok;
      mslp_pkg::CMD_TOUCH,
      mslp_pkg::CMD_Q_ELEM:   bad = !idx_ok;
      default:                bad = 1'b1;
    endcase
    empty = (in_ch.cmd == mslp_pkg::CMD_MOVE_OLD || in_ch.cmd == mslp_pkg::CMD_Q_STATE) &&
            (q_rd.head == mslp_pkg::NIL);
  end

  // New stamp: input time or saturating counter
  always_comb begin
    if (timed_r) begin
      stamp_calc = now_r;
    end else if (ctr_r != mslp_pkg::STAMP_MAX) begin
      stamp_calc = ctr_r + 1'b1;
    end else begin
      stamp_calc = ctr_r;
    end
  end

  // Sequencer: memory and queue-table port control
  always_comb begin
    fsm_nxt = fsm_r;
    res_nxt = res_r;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    inf_we = 1'b0; inf_wa = '0; inf_wd = '0;
    rd_en = 1'b0; rd_a = '0;
    q_sel = os_r; q_we = 1'b0; q_wd = q_rd;
    unique case (fsm_r)
      S_CLR: begin
        nx_we  = 1'b1; nx_wa = clr_r;
        nx_wd  = (clr_r == '0) ? mslp_pkg::NIL : mslp_pkg::LINK_W'(clr_r) - 1'b1;
        pv_we  = 1'b1; pv_wa = clr_r;
        pv_wd  = (clr_r == mslp_pkg::IDX_W'(mslp_pkg::ELEMENTS - 1)) ? mslp_pkg::NIL :
                 mslp_pkg::LINK_W'(clr_r) + 1'b1;
        inf_we = 1'b1; inf_wa = clr_r;
        inf_wd = {mslp_pkg::STATE_W'(0),
                  mslp_pkg::STAMP_W'(mslp_pkg::ELEMENTS) - mslp_pkg::STAMP_W'(clr_r)};
        if (clr_r == mslp_pkg::IDX_W'(mslp_pkg::ELEMENTS - 1)) begin
          fsm_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        q_sel = in_ch.src_state;
        rd_a  = (in_ch.cmd == mslp_pkg::CMD_MOVE_OLD || in_ch.cmd == mslp_pkg::CMD_Q_STATE) ?
                q_rd.head[mslp_pkg::IDX_W-1:0] : in_ch.element_index;
        if (in_acc) begin
          if (bad) begin
            res_nxt = '0;
            res_nxt.status = mslp_pkg::STS_BAD;
            fsm_nxt = S_OUT;
          end else if (empty) begin
            res_nxt = '0;
            res_nxt.status = mslp_pkg::STS_EMPTY;
            fsm_nxt = S_OUT;
          end else begin
            rd_en   = 1'b1;
            fsm_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        q_sel = (cmd_r == mslp_pkg::CMD_Q_ELEM) ? st_q : os_r;
        res_nxt.status        = mslp_pkg::STS_OK;
        res_nxt.result_index  = e_r;
        res_nxt.current_state = st_q;
        res_nxt.stamp         = stp_q;
        res_nxt.state_count   = q_rd.len;
        if (cmd_r == mslp_pkg::CMD_Q_ELEM) begin
          fsm_nxt = S_OUT;
        end else if (cmd_r == mslp_pkg::CMD_Q_STATE) begin
          res_nxt.current_state = os_r;
          fsm_nxt = S_OUT;
        end else if (cmd_r == mslp_pkg::CMD_MOVE_IDX && st_q != os_r) begin
          res_nxt.status = mslp_pkg::STS_WRONG;
          fsm_nxt = S_OUT;
        end else begin
          fsm_nxt = S_UNLINK;
        end
      end
      S_UNLINK: begin
        q_sel = src_r;
        q_we  = 1'b1;
        if (p_r == mslp_pkg::NIL) begin
          q_wd.head = n_r;
        end
        if (n_r == mslp_pkg::NIL) begin
          q_wd.tail = p_r;
        end
        q_wd.len = q_rd.len - 1'b1;
        nx_we  = (p_r != mslp_pkg::NIL); nx_wa = p_r[mslp_pkg::IDX_W-1:0]; nx_wd = n_r;
        pv_we  = (n_r != mslp_pkg::NIL); pv_wa = n_r[mslp_pkg::IDX_W-1:0]; pv_wd = p_r;
        inf_we = 1'b1; inf_wa = e_r; inf_wd = {dst_r, stamp_calc};
        fsm_nxt = S_LINK;
      end
      S_LINK: begin
        q_sel = dst_r;
        q_we  = 1'b1;
        if (q_rd.tail == mslp_pkg::NIL) begin
          q_wd.head = {1'b0, e_r};
        end
        q_wd.tail = {1'b0, e_r};
        q_wd.len  = q_rd.len + 1'b1;
        nx_we = 1'b1; nx_wa = e_r; nx_wd = mslp_pkg::NIL;
        pv_we = 1'b1; pv_wa = e_r; pv_wd = q_rd.tail;
        fsm_nxt = S_FIX;
      end
      S_FIX: begin
        q_sel = src_r;
        nx_we = (t_r != mslp_pkg::NIL); nx_wa = t_r[mslp_pkg::IDX_W-1:0]; nx_wd = {1'b0, e_r};
        res_nxt.status        = mslp_pkg::STS_OK;
        res_nxt.result_index  = e_r;
        res_nxt.current_state = dst_r;
        res_nxt.stamp         = stamp_new_r;
        res_nxt.state_count   = q_rd.len;
        fsm_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          fsm_nxt = S_IDLE;
        end
      end
      default: fsm_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      siu_r       <= mslp_pkg::SIU_W'(8);
      timed_r     <= 1'b0;
      ctr_r       <= mslp_pkg::STAMP_W'(mslp_pkg::ELEMENTS);
    end else begin
      fsm_r <= fsm_nxt;
      if (fsm_r == S_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.reg_index)
          mslp_pkg::REG_STATES_IN_USE: siu_r   <= cfg_ch.data;
          mslp_pkg::REG_TIMED_MODE:    timed_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (fsm_r == S_UNLINK && !timed_r) begin
        ctr_r <= stamp_calc;
      end
      // Output register: load from the result stage, drop on handshake
      if (fsm_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (fsm_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_r <= res_r;
    end
    if (in_acc) begin
      cmd_r <= in_ch.cmd;
      os_r  <= in_ch.src_state;
      ns_r  <= in_ch.dst_state;
      now_r <= in_ch.now;
      e_r   <= rd_a;
    end
    if (fsm_r == S_EVAL) begin
      n_r   <= nx_q;
      p_r   <= pv_q;
      src_r <= st_q;
      dst_r <= (cmd_r == mslp_pkg::CMD_TOUCH) ? st_q : ns_r;
    end
    if (fsm_r == S_UNLINK) begin
      stamp_new_r <= stamp_calc;
    end
    if (fsm_r == S_LINK) begin
      t_r <= q_rd.tail;
    end
  end

endmodule

// ----- design/mslp_checker.sv -----
// Port-level checks of the LRU pool, bound to the top level.
module mslp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mslp_pkg::STS_W-1:0]   status,
  input logic [mslp_pkg::IDX_W-1:0]   result_index,
  input logic [mslp_pkg::STAMP_W-1:0] stamp,
  input logic [mslp_pkg::CNT_W-1:0]   state_count
);

  // A result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before handshake");

  // One transaction in flight: not ready right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted back to back");

  // Bad argument carries an all-zero payload
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == mslp_pkg::STS_BAD |->
      result_index == '0 && stamp == '0 && state_count == '0)
    else $error("bad argument result not zeroed");

  // Empty queue reports zero count and stamp
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == mslp_pkg::STS_EMPTY |-> state_count == '0 && stamp == '0)
    else $error("empty queue result not zeroed");

endmodule

bind multi_state_lru_pool mslp_checker u_mslp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .result_index (out_ch.result_index),
  .stamp        (out_ch.stamp),
  .state_count  (out_ch.state_count)
);

// ----- tb/multi_state_lru_pool_tb.sv -----
// Self-checking testbench for the multi-state LRU pool: directed and random commands.

// Tracks the pool contents and holds the results the block must produce, oldest first
class pool_scoreboard;
  logic [mslp_pkg::LINK_W-1:0]  nxt [mslp_pkg::ELEMENTS];
  logic [mslp_pkg::LINK_W-1:0]  prv [mslp_pkg::ELEMENTS];
  logic [mslp_pkg::STATE_W-1:0] est [mslp_pkg::ELEMENTS];
  logic [mslp_pkg::STAMP_W-1:0] estamp [mslp_pkg::ELEMENTS];
  logic [mslp_pkg::LINK_W-1:0]  qhead [mslp_pkg::STATES];
  logic [mslp_pkg::LINK_W-1:0]  qtail [mslp_pkg::STATES];
  logic [mslp_pkg::CNT_W-1:0]   qlen [mslp_pkg::STATES];
  logic [mslp_pkg::STAMP_W-1:0] insert_cnt;
  int unsigned                  states_in_use;
  bit                           timed;
  mslp_pkg::result_t            pending [$];
  int unsigned                  mismatches;
  int unsigned                  checked;

  function new();
    for (int i = 0; i < mslp_pkg::ELEMENTS; i++) begin
      nxt[i] = (i == 0) ? mslp_pkg::NIL : mslp_pkg::LINK_W'(i - 1);
      prv[i] = (i == mslp_pkg::ELEMENTS - 1) ? mslp_pkg::NIL : mslp_pkg::LINK_W'(i + 1);
      est[i] = '0;
      estamp[i] = mslp_pkg::STAMP_W'(mslp_pkg::ELEMENTS - i);
    end
    for (int s = 0; s < mslp_pkg::STATES; s++) begin
      qhead[s] = mslp_pkg::NIL;
      qtail[s] = mslp_pkg::NIL;
      qlen[s] = '0;
    end
    qhead[0] = mslp_pkg::LINK_W'(mslp_pkg::ELEMENTS - 1);
    qtail[0] = '0;
    qlen[0] = mslp_pkg::CNT_W'(mslp_pkg::ELEMENTS);
    insert_cnt = mslp_pkg::STAMP_W'(mslp_pkg::ELEMENTS);
    states_in_use = 8;
    timed = 0;
    mismatches = 0;
    checked = 0;
  endfunction

  function bit valid_state(int unsigned s);
    return s < states_in_use && s < mslp_pkg::STATES;
  endfunction

  // Pull an element out of its queue, restamp it and append it to queue q
  function void requeue(int unsigned e, int unsigned q, logic [mslp_pkg::STAMP_W-1:0] now);
    int unsigned o;
    logic [mslp_pkg::LINK_W-1:0] p, n;
    o = est[e];
    p = prv[e];
    n = nxt[e];
    if (p == mslp_pkg::NIL) qhead[o] = n; else nxt[p] = n;
    if (n == mslp_pkg::NIL) qtail[o] = p; else prv[n] = p;
    qlen[o]--;
    if (timed) estamp[e] = now;
    else begin
      if (insert_cnt != mslp_pkg::STAMP_MAX) insert_cnt++;
      estamp[e] = insert_cnt;
    end
    prv[e] = qtail[q];
    nxt[e] = mslp_pkg::NIL;
    if (qtail[q] == mslp_pkg::NIL) qhead[q] = mslp_pkg::LINK_W'(e);
    else nxt[qtail[q]] = mslp_pkg::LINK_W'(e);
    qtail[q] = mslp_pkg::LINK_W'(e);
    qlen[q]++;
    est[e] = mslp_pkg::STATE_W'(q);
  endfunction

  // Work out the result of one accepted command transaction
  function void note_command(logic [mslp_pkg::CMD_W-1:0] cmd, logic [mslp_pkg::IDX_W-1:0] idx,
                             logic [mslp_pkg::STATE_W-1:0] os,
                             logic [mslp_pkg::STATE_W-1:0] ns,
                             logic [mslp_pkg::STAMP_W-1:0] now);
    mslp_pkg::result_t r;
    int unsigned e, q;
    r = '0;
    r.status = mslp_pkg::STS_BAD;
    case (cmd)
      mslp_pkg::CMD_MOVE_IDX: begin
        if (valid_state(os) && valid_state(ns)) begin
          e = idx;
          if (est[e] != os) begin
            r = '{mslp_pkg::STS_WRONG, idx, est[e], estamp[e], qlen[os]};
          end else begin
            requeue(e, ns, now);
            r = '{mslp_pkg::STS_OK, idx, ns, estamp[e], qlen[os]};
          end
        end
      end
      mslp_pkg::CMD_MOVE_OLD, mslp_pkg::CMD_Q_STATE: begin
        if (valid_state(os) && (cmd == mslp_pkg::CMD_Q_STATE || valid_state(ns))) begin
          if (qhead[os] == mslp_pkg::NIL) begin
            r = '0;
            r.status = mslp_pkg::STS_EMPTY;
          end else begin
            e = qhead[os];
            if (cmd == mslp_pkg::CMD_MOVE_OLD) begin
              requeue(e, ns, now);
              r = '{mslp_pkg::STS_OK, mslp_pkg::IDX_W'(e), ns, estamp[e], qlen[os]};
            end else
              r = '{mslp_pkg::STS_OK, mslp_pkg::IDX_W'(e), os, estamp[e], qlen[os]};
          end
        end
      end
      mslp_pkg::CMD_TOUCH: begin
        e = idx;
        q = est[e];
        requeue(e, q, now);
        r = '{mslp_pkg::STS_OK, idx, mslp_pkg::STATE_W'(q), estamp[e], qlen[q]};
      end
      mslp_pkg::CMD_Q_ELEM: begin
        e = idx;
        q = est[e];
        r = '{mslp_pkg::STS_OK, idx, mslp_pkg::STATE_W'(q), estamp[e], qlen[q]};
      end
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  // Compare one accepted result against the oldest expectation
  function void check_result(mslp_pkg::result_t got);
    mslp_pkg::result_t exp_r;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got.status !== exp_r.status || got.result_index !== exp_r.result_index ||
        got.current_state !== exp_r.current_state || got.stamp !== exp_r.stamp ||
        got.state_count !== exp_r.state_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: result %0d expected sts=%0d idx=%0d st=%0d stamp=%0h cnt=%0d,",
                  " got sts=%0d idx=%0d st=%0d stamp=%0h cnt=%0d"},
                 checked, exp_r.status, exp_r.result_index, exp_r.current_state,
                 exp_r.stamp, exp_r.state_count, got.status, got.result_index,
                 got.current_state, got.stamp, got.state_count);
    end
  endfunction
endclass

module multi_state_lru_pool_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 6000;

  logic clk;
  logic rst_n;

  mslp_in_if  in_ch();
  mslp_out_if out_ch();
  mslp_cfg_if cfg_ch();

  multi_state_lru_pool u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pool_scoreboard sb;
  int unsigned    idle_cycles;
  int unsigned    sink_stall;
  bit             sink_steady;
  int unsigned    n_cmds;
  int unsigned    n_cfg;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Short gaps mostly, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Record accepted transactions; watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_command(in_ch.cmd, in_ch.element_index, in_ch.src_state,
                        in_ch.dst_state, in_ch.now);
        n_cmds++;
      end
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.status, out_ch.result_index, out_ch.current_state,
                          out_ch.stamp, out_ch.state_count});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    if (!rst_n || sink_steady) begin
      out_ch.ready <= 1'b1;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      sink_stall <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  // Drive one command; valid stays high when the next one follows without a gap
  task automatic send_cmd(logic [mslp_pkg::CMD_W-1:0] cmd, logic [mslp_pkg::IDX_W-1:0] idx,
                          logic [mslp_pkg::STATE_W-1:0] os,
                          logic [mslp_pkg::STATE_W-1:0] ns,
                          logic [mslp_pkg::STAMP_W-1:0] now, int unsigned gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.element_index <= idx;
    in_ch.src_state <= os;
    in_ch.dst_state <= ns;
    in_ch.now <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off until every result is in, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [mslp_pkg::CFG_IDX_W-1:0] ridx,
                           logic [mslp_pkg::CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= ridx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (ridx == mslp_pkg::REG_STATES_IN_USE) sb.states_in_use = val;
    else if (ridx == mslp_pkg::REG_TIMED_MODE) sb.timed = val[0];
    n_cfg++;
    @(posedge clk);
  endtask

  function automatic logic [mslp_pkg::STAMP_W-1:0] rand_now();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // A state valid under the current setting, at times any; any state when none is valid
  function automatic logic [mslp_pkg::STATE_W-1:0] pick_state();
    int unsigned lim;
    lim = (sb.states_in_use > mslp_pkg::STATES) ? mslp_pkg::STATES : sb.states_in_use;
    if (lim == 0 || $urandom_range(0, 19) == 0) return mslp_pkg::STATE_W'($urandom);
    return mslp_pkg::STATE_W'($urandom_range(0, lim - 1));
  endfunction

  // Random commands, some undefined; moves by index mostly follow the element's real state
  task automatic random_cmds(int unsigned count);
    int unsigned r;
    logic [mslp_pkg::IDX_W-1:0] idx;
    logic [mslp_pkg::STATE_W-1:0] os;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      idx = mslp_pkg::IDX_W'($urandom);
      if (r < 35) begin
        os = ($urandom_range(0, 9) < 8) ? sb.est[idx] : pick_state();
        send_cmd(mslp_pkg::CMD_MOVE_IDX, idx, os, pick_state(), rand_now(), pick_gap());
      end else if (r < 55)
        send_cmd(mslp_pkg::CMD_MOVE_OLD, idx, pick_state(), pick_state(), rand_now(),
                 pick_gap());
      else if (r < 67)
        send_cmd(mslp_pkg::CMD_TOUCH, idx, mslp_pkg::STATE_W'($urandom),
                 mslp_pkg::STATE_W'($urandom), rand_now(), pick_gap());
      else if (r < 79)
        send_cmd(mslp_pkg::CMD_Q_STATE, idx, pick_state(), mslp_pkg::STATE_W'($urandom),
                 rand_now(), pick_gap());
      else if (r < 91)
        send_cmd(mslp_pkg::CMD_Q_ELEM, idx, mslp_pkg::STATE_W'($urandom),
                 mslp_pkg::STATE_W'($urandom), rand_now(), pick_gap());
      else
        send_cmd(mslp_pkg::CMD_W'($urandom), idx, mslp_pkg::STATE_W'($urandom),
                 mslp_pkg::STATE_W'($urandom), rand_now(), pick_gap());
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    n_cmds = 0;
    n_cfg = 0;
    sink_steady = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = mslp_pkg::CMD_Q_ELEM;
    in_ch.element_index = '0;
    in_ch.src_state = '0;
    in_ch.dst_state = '0;
    in_ch.now = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = mslp_pkg::REG_STATES_IN_USE;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, extremes, each command and the special cases
    send_cmd(mslp_pkg::CMD_Q_STATE, '0, 3'd0, '0, '0, 0);
    send_cmd(mslp_pkg::CMD_Q_ELEM, '0, '0, '0, '0, 0);
    send_cmd(mslp_pkg::CMD_Q_ELEM, '1, '1, '1, '1, 0);
    send_cmd(mslp_pkg::CMD_MOVE_IDX, '1, 3'd0, 3'd7, '1, 0);
    send_cmd(mslp_pkg::CMD_MOVE_IDX, '1, 3'd0, 3'd3, '0, 1);
    send_cmd(mslp_pkg::CMD_MOVE_OLD, '0, 3'd5, 3'd1, '0, 0);
    send_cmd(mslp_pkg::CMD_Q_STATE, '0, 3'd5, 3'd0, '0, 0);
    send_cmd(mslp_pkg::CMD_MOVE_OLD, '0, 3'd0, 3'd7, '0, 2);
    send_cmd(mslp_pkg::CMD_Q_STATE, '0, 3'd7, 3'd0, '0, 0);
    send_cmd(mslp_pkg::CMD_MOVE_IDX, '1, 3'd7, 3'd7, '0, 0);
    send_cmd(mslp_pkg::CMD_TOUCH, 10'd512, '0, '0, '0, 0);
    send_cmd(mslp_pkg::CMD_MOVE_OLD, '0, 3'd7, 3'd7, '0, 0);
    send_cmd(3'd5, '1, '1, '1, '1, 0);
    send_cmd(3'd6, '0, '0, '0, '0, 0);
    send_cmd(3'd7, 10'd5, 3'd2, 3'd2, '0, 0);
    drain();

    // Timed stamps with extreme times, then a restricted state set
    write_reg(mslp_pkg::REG_TIMED_MODE, 4'd1);
    write_reg(mslp_pkg::REG_STATES_IN_USE, 4'd3);
    send_cmd(mslp_pkg::CMD_TOUCH, 10'd1, '0, '0, '1, 0);
    send_cmd(mslp_pkg::CMD_MOVE_IDX, 10'd2, 3'd0, 3'd2, 48'h5555_AAAA_5555, 0);
    send_cmd(mslp_pkg::CMD_MOVE_IDX, 10'd3, 3'd0, 3'd3, '1, 0);
    send_cmd(mslp_pkg::CMD_MOVE_OLD, '0, 3'd4, 3'd1, '0, 0);
    send_cmd(mslp_pkg::CMD_Q_STATE, '0, 3'd3, '0, '0, 0);
    send_cmd(mslp_pkg::CMD_TOUCH, '1, '0, '0, 48'hAAAA_5555_AAAA, 0);
    send_cmd(mslp_pkg::CMD_Q_ELEM, '1, '0, '0, '0, 0);
    random_cmds(250);
    drain();

    // Single valid state, counter stamps, result side never stalled
    sink_steady = 1'b1;
    write_reg(mslp_pkg::REG_STATES_IN_USE, 4'd1);
    write_reg(mslp_pkg::REG_TIMED_MODE, 4'd0);
    random_cmds(120);
    drain();
    sink_steady = 1'b0;

    // No valid state at all, then the top of the register range
    write_reg(mslp_pkg::REG_STATES_IN_USE, 4'd0);
    random_cmds(40);
    drain();
    write_reg(mslp_pkg::REG_STATES_IN_USE, 4'd15);
    write_reg(mslp_pkg::REG_TIMED_MODE, 4'd1);
    random_cmds(350);
    drain();

    write_reg(mslp_pkg::REG_STATES_IN_USE, 4'd8);
    write_reg(mslp_pkg::REG_TIMED_MODE, 4'd0);
    random_cmds(300);
    drain();

    write_reg(mslp_pkg::REG_STATES_IN_USE, 4'd5);
    random_cmds(250);
    drain();

    $display("Covered %0d commands and %0d register writes over state limits 0..15,",
             n_cmds, n_cfg);
    $display("counter and timed stamps; %0d results checked, %0d mismatches.",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
